// ===== rtl/lfm_chirp_echo_injector_unit_assert.svh =====
// Assertion macros for the chirp echo injector
`ifndef LFM_CHIRP_ECHO_INJECTOR_UNIT_ASSERT_SVH
`define LFM_CHIRP_ECHO_INJECTOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define LCEI_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lcei assertion failed");
// Next-cycle implication checked outside reset
`define LCEI_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lcei assertion failed");
`endif

// ===== rtl/lcei_pkg.sv =====
// ----------------------------------------------------------------------------
// lcei_pkg
// Shared types, constants and CORDIC table of the chirp echo injector.
// ----------------------------------------------------------------------------
package lcei_pkg;
    localparam int MAX_PULSE_SAMPLES = 16384;
    localparam int PHASE_BITS        = 16;
    localparam int CORDIC_STEPS      = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE = 3'd0,
        REG_DELAY     = 3'd1,
        REG_SPAN      = 3'd2,
        REG_SAMPLES   = 3'd3,
        REG_PULSE_LEN = 3'd4,
        REG_RATE      = 3'd5,
        REG_CARRIER   = 3'd6
    } t_reg_idx;

    // Side data carried alongside the rotation in every cell
    typedef struct packed {
        logic               hit;
        logic               last;
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic        [1:0]  quad;
        logic        [14:0] amp;
    } t_side;

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic signed [23:0] atan_lut(input logic [3:0] i);
        case (i)
            4'd0:  atan_lut = 24'sd2097152;
            4'd1:  atan_lut = 24'sd1238021;
            4'd2:  atan_lut = 24'sd654136;
            4'd3:  atan_lut = 24'sd332050;
            4'd4:  atan_lut = 24'sd166669;
            4'd5:  atan_lut = 24'sd83416;
            4'd6:  atan_lut = 24'sd41718;
            4'd7:  atan_lut = 24'sd20860;
            4'd8:  atan_lut = 24'sd10430;
            4'd9:  atan_lut = 24'sd5215;
            4'd10: atan_lut = 24'sd2608;
            4'd11: atan_lut = 24'sd1304;
            4'd12: atan_lut = 24'sd652;
            4'd13: atan_lut = 24'sd326;
            4'd14: atan_lut = 24'sd163;
            default: atan_lut = 24'sd81;
        endcase
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [35:0] v);
        if (v > 36'sd32767) clamp16 = 16'sh7fff;
        else if (v < -36'sd32768) clamp16 = 16'sh8000;
        else clamp16 = v[15:0];
    endfunction
endpackage

// ===== rtl/lcei_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcei_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface lcei_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lfm_chirp_echo_injector_unit.sv =====
// ----------------------------------------------------------------------------
// lfm_chirp_echo_injector_unit
// Adds a linear-FM target echo to a receive sample stream.
// ----------------------------------------------------------------------------
// One sample word is taken every clock while the pipeline is not stalled, and
// passes through the window test and phase arithmetic (the 44-bit square and
// the rate product, formed as two 32 x 22 halves side by side, each own a
// stage), sixteen CORDIC cells in a row, one scaling stage and one output
// register. The whole pipeline stalls together when the output is not taken,
// so throughput is one word per clock only while the output is taken.
`include "lfm_chirp_echo_injector_unit_assert.svh"
module lfm_chirp_echo_injector_unit #(
    parameter int MAX_PULSE_SAMPLES = lcei_pkg::MAX_PULSE_SAMPLES,
    parameter int PHASE_BITS        = lcei_pkg::PHASE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lcei_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lcei_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lcei_stream_if.sink                      s_in,
    lcei_stream_if.source                    m_out
);
    localparam int N = lcei_pkg::CORDIC_STEPS;

    logic [14:0]        r_amp, r_samples, r_plen;
    logic [21:0]        r_delay, r_span;
    logic signed [31:0] r_rate;
    logic [15:0]        r_carrier;

    // write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= '0; r_delay <= '0; r_span <= '0; r_samples <= '0;
            r_plen <= 15'd16384; r_rate <= '0; r_carrier <= '0;
        end else if (i_cfg_we) begin
            unique case (lcei_pkg::t_reg_idx'(i_cfg_idx))
                lcei_pkg::REG_AMPLITUDE: r_amp     <= i_cfg_data[14:0];
                lcei_pkg::REG_DELAY:     r_delay   <= i_cfg_data[21:0];
                lcei_pkg::REG_SPAN:      r_span    <= i_cfg_data[21:0];
                lcei_pkg::REG_SAMPLES:   r_samples <= i_cfg_data[14:0];
                lcei_pkg::REG_PULSE_LEN: r_plen    <= i_cfg_data[14:0];
                lcei_pkg::REG_RATE:      r_rate    <= i_cfg_data[31:0];
                lcei_pkg::REG_CARRIER:   r_carrier <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances when the output register is free
    logic en;
    assign en = !m_out.valid || m_out.ready;
    assign s_in.ready = en;

    logic        f_vld;
    logic [23:0] f_ph;
    lcei_pkg::t_side f_side;

    lcei_phase_front #(.MAX_PULSE_SAMPLES(MAX_PULSE_SAMPLES), .PHASE_BITS(PHASE_BITS))
    u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(s_in.valid), .i_idx(s_in.data.sample_index),
        .i_in_i(s_in.data.in_i), .i_in_q(s_in.data.in_q), .i_last(s_in.data.in_last),
        .i_amp(r_amp), .i_delay(r_delay), .i_span(r_span), .i_samples(r_samples),
        .i_plen(r_plen), .i_rate(r_rate), .i_carrier(r_carrier),
        .o_vld(f_vld), .o_ph24(f_ph), .o_side(f_side)
    );

    // chain of rotation cells
    logic               c_vld [N+1];
    logic signed [33:0] c_x   [N+1];
    logic signed [33:0] c_y   [N+1];
    logic signed [24:0] c_z   [N+1];
    lcei_pkg::t_side    c_side[N+1];

    always_comb begin
        c_vld[0]  = f_vld;
        c_x[0]    = lcei_pkg::CORDIC_GAIN_INIT;
        c_y[0]    = '0;
        c_z[0]    = {3'b000, f_ph[21:0]};
        c_side[0] = f_side;
        c_side[0].quad = f_ph[23:22];
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lcei_cordic_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_vld(c_vld[g]), .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
            .i_side(c_side[g]),
            .o_vld(c_vld[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1]),
            .o_side(c_side[g+1])
        );
    end

    // round, fold quadrant, scale
    logic signed [15:0] c_c, c_s;
    logic signed [16:0] q_c, q_s;
    assign c_c = lcei_pkg::clamp16(36'((c_x[N] + 34'sd16384) >>> 15));
    assign c_s = lcei_pkg::clamp16(36'((c_y[N] + 34'sd16384) >>> 15));
    // widen before negating: minus full scale has no 16-bit opposite
    always_comb begin
        case (c_side[N].quad)
            2'd0:    begin q_c = 17'(c_c);  q_s = 17'(c_s);  end
            2'd1:    begin q_c = -17'(c_s); q_s = 17'(c_c);  end
            2'd2:    begin q_c = -17'(c_c); q_s = -17'(c_s); end
            default: begin q_c = 17'(c_s);  q_s = -17'(c_c); end
        endcase
    end

    logic               r_s_vld;
    logic signed [31:0] r_ei, r_eq;
    lcei_pkg::t_side    r_s_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s_vld <= 1'b0;
        else if (en) r_s_vld <= c_vld[N];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ei     <= $signed({17'd0, c_side[N].amp}) * 32'(q_c);
            r_eq     <= $signed({17'd0, c_side[N].amp}) * 32'(q_s);
            r_s_side <= c_side[N];
        end
    end

    // add echo with saturation and hold the output word
    logic signed [35:0] e_i, e_q, s_i, s_q;
    assign e_i = 36'((36'(r_ei) + 36'sd16384) >>> 15);
    assign e_q = 36'((36'(r_eq) + 36'sd16384) >>> 15);
    assign s_i = 36'(r_s_side.in_i) + (r_s_side.hit ? e_i : 36'sd0);
    assign s_q = 36'(r_s_side.in_q) + (r_s_side.hit ? e_q : 36'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_out.valid <= 1'b0;
        else if (en) m_out.valid <= r_s_vld;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_out.data.out_i    <= lcei_pkg::clamp16(s_i);
            m_out.data.out_q    <= lcei_pkg::clamp16(s_q);
            m_out.data.injected <= r_s_side.hit;
            m_out.data.out_last <= r_s_side.last;
        end
    end

    `LCEI_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        !s_in.ready)
    `LCEI_ASSERT_NXT(a_no_inj_zero_amp, i_clk, i_rst_n,
        en && r_s_vld && !r_s_side.hit, m_out.data.injected == 1'b0)
    `LCEI_ASSERT_IMP(a_amp_off, i_clk, i_rst_n, f_vld && f_side.amp == '0,
        !f_side.hit)
endmodule

// ===== rtl/lcei_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// lcei_cordic_cell
// One CORDIC rotation step; hands its result to the next cell every cycle while enabled.
// ----------------------------------------------------------------------------
module lcei_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic signed [33:0]    i_x,
    input  logic signed [33:0]    i_y,
    input  logic signed [24:0]    i_z,
    input  lcei_pkg::t_side       i_side,
    output logic                  o_vld,
    output logic signed [33:0]    o_x,
    output logic signed [33:0]    o_y,
    output logic signed [24:0]    o_z,
    output lcei_pkg::t_side       o_side
);
    logic signed [33:0] dx, dy;
    logic signed [24:0] at;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;
    assign at = 25'(lcei_pkg::atan_lut(4'(STEP)));

    // hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_vld <= 1'b0;
        else if (i_en) o_vld <= i_vld;
    end

    // rotate towards zero residual angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (!i_z[24]) begin
                o_x <= i_x - dx; o_y <= i_y + dy; o_z <= i_z - at;
            end else begin
                o_x <= i_x + dx; o_y <= i_y - dy; o_z <= i_z + at;
            end
        end
    end
endmodule

// ===== rtl/lcei_phase_front.sv =====
// ----------------------------------------------------------------------------
// lcei_phase_front
// Window test and chirp phase: offset, square, rate product, rounding.
// ----------------------------------------------------------------------------
module lcei_phase_front #(
    parameter int MAX_PULSE_SAMPLES = lcei_pkg::MAX_PULSE_SAMPLES,
    parameter int PHASE_BITS        = lcei_pkg::PHASE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [13:0]          i_idx,
    input  logic signed [15:0]   i_in_i,
    input  logic signed [15:0]   i_in_q,
    input  logic                 i_last,
    input  logic [14:0]          i_amp,
    input  logic [21:0]          i_delay,
    input  logic [21:0]          i_span,
    input  logic [14:0]          i_samples,
    input  logic [14:0]          i_plen,
    input  logic signed [31:0]   i_rate,
    input  logic [15:0]          i_carrier,
    output logic                 o_vld,
    output logic [23:0]          o_ph24,
    output lcei_pkg::t_side      o_side
);
    localparam logic [16:0] PL_MAX = 17'(MAX_PULSE_SAMPLES);

    // stage 1: window and offset
    logic [16:0] plen_c;
    logic [22:0] start_end;
    logic [21:0] n256;
    logic [21:0] d_c;
    logic        win;
    logic        r1_vld, r2_vld, r3_vld;
    logic [21:0] r1_d;
    lcei_pkg::t_side r1_side, r2_side, r3_side;
    logic [43:0] r2_dd;
    logic [55:0] r3_lo;
    logic [33:0] r3_hi;
    logic [55:0] total;
    logic [55:0] rnd;
    logic [PHASE_BITS-1:0] ph;

    assign plen_c    = (17'(i_plen) > PL_MAX) ? PL_MAX : 17'(i_plen);
    assign start_end = 23'(i_delay[21:8]) + 23'(i_samples);
    assign n256      = {i_idx, 8'd0};
    assign d_c       = n256 - i_delay;
    assign win = (i_amp != '0) && (17'(i_idx) < plen_c) && (i_idx >= i_delay[21:8])
               && (23'(i_idx) < start_end) && (n256 >= i_delay) && (d_c < i_span);

    // advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0; o_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld; r2_vld <= r1_vld; r3_vld <= r2_vld; o_vld <= r3_vld;
        end
    end

    // join the two partial products; only the low 56 bits reach the phase
    assign total = r3_lo + {r3_hi, 22'd0};
    assign rnd   = total + (56'd1 << (55 - PHASE_BITS));
    assign ph    = rnd[55:56-PHASE_BITS];

    // offset, square, rate product in two halves, round
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= d_c;
            r1_side <= '{hit: win, last: i_last, in_i: i_in_i, in_q: i_in_q,
                         quad: 2'd0, amp: i_amp};
            r2_dd   <= 44'(r1_d) * 44'(r1_d);
            r2_side <= r1_side;
            r3_lo   <= 56'($signed(i_rate) * $signed({1'b0, r2_dd[21:0]}))
                     + {i_carrier, 40'd0};
            r3_hi   <= 34'($signed(i_rate) * $signed({1'b0, r2_dd[43:22]}));
            r3_side <= r2_side;
            o_ph24  <= 24'({ph, {(24-PHASE_BITS){1'b0}}});
            o_side  <= r3_side;
        end
    end
endmodule

// ===== sim/lcei_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcei_tb_pkg
// Word layouts of the sample and result channels used by the testbench.
// ----------------------------------------------------------------------------
package lcei_tb_pkg;
    // Receive sample word with its range index
    typedef struct packed {
        logic        [13:0] sample_index;
        logic signed [15:0] in_i;
        logic signed [15:0] in_q;
        logic               in_last;
    } t_sample_in;

    // Sample word after echo injection
    typedef struct packed {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
        logic               injected;
        logic               out_last;
    } t_sample_out;
endpackage

// ===== sim/echo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_checker
// Watches the register port and both channels, works out the expected word of
// each accepted sample from its own copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module echo_checker
    import lcei_pkg::*;
    import lcei_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_sample_in            i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_sample_out           i_out_data,
    output int                    o_fail_cnt,
    output int                    o_pending,
    output int                    o_echo_cnt,
    output int                    o_word_cnt
);
    localparam longint GAIN = 652032874;

    logic [14:0] amp_q;
    logic [21:0] delay_q;
    logic [21:0] span_q;
    logic [14:0] nsamp_q;
    logic [14:0] plen_q;
    logic [31:0] rate_q;
    logic [15:0] carrier_q;

    t_sample_out expected_words[$];

    function automatic longint atan_turns(input int i);
        longint tab[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                            20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return tab[i];
    endfunction

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Sine and cosine of a 16-bit phase, rotated in 16 steps
    function automatic void rotate_phase(input logic [15:0] ph, output longint co,
                                         output longint si);
        logic [23:0] ph24;
        longint      x, y, z, dx, dy, c, s;
        ph24 = {ph, 8'd0};
        x = GAIN;
        y = 0;
        z = longint'(ph24[21:0]);
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_turns(i);
            end else begin
                x += dx; y -= dy; z += atan_turns(i);
            end
        end
        c = sat16((x + 16384) >>> 15);
        s = sat16((y + 16384) >>> 15);
        case (ph24[23:22])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endfunction

    // Expected word for one accepted sample
    function automatic t_sample_out inject_echo(input t_sample_in w);
        t_sample_out r;
        longint      oi, oq, co, si;
        logic [63:0] n, plen, start, d, total;
        logic [15:0] ph;
        n = 64'(w.sample_index);
        plen = (plen_q > MAX_PULSE_SAMPLES) ? 64'(MAX_PULSE_SAMPLES) : 64'(plen_q);
        start = 64'(delay_q >> 8);
        oi = longint'(w.in_i);
        oq = longint'(w.in_q);
        r.injected = 1'b0;
        if (amp_q != 0 && n < plen && n >= start && n < start + 64'(nsamp_q)
                && n * 256 >= 64'(delay_q)) begin
            d = n * 256 - 64'(delay_q);
            if (d < 64'(span_q)) begin
                total = {{32{rate_q[31]}}, rate_q} * (d * d) + (64'(carrier_q) << 40);
                ph = 16'((total + (64'd1 << 39)) >> 40);
                rotate_phase(ph, co, si);
                oi += (longint'(amp_q) * co + 16384) >>> 15;
                oq += (longint'(amp_q) * si + 16384) >>> 15;
                r.injected = 1'b1;
            end
        end
        r.out_i = 16'(sat16(oi));
        r.out_q = 16'(sat16(oq));
        r.out_last = w.in_last;
        return r;
    endfunction

    assign o_pending = expected_words.size();

    // Shadow the registers, predict on input, compare on output
    always @(posedge i_clk) begin
        t_sample_out want;
        if (!i_rst_n) begin
            amp_q <= '0; delay_q <= '0; span_q <= '0; nsamp_q <= '0;
            plen_q <= 15'd16384; rate_q <= '0; carrier_q <= '0;
            o_fail_cnt <= 0; o_echo_cnt <= 0; o_word_cnt <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_AMPLITUDE: amp_q     <= i_cfg_data[14:0];
                    REG_DELAY:     delay_q   <= i_cfg_data[21:0];
                    REG_SPAN:      span_q    <= i_cfg_data[21:0];
                    REG_SAMPLES:   nsamp_q   <= i_cfg_data[14:0];
                    REG_PULSE_LEN: plen_q    <= i_cfg_data[14:0];
                    REG_RATE:      rate_q    <= i_cfg_data;
                    REG_CARRIER:   carrier_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) expected_words.push_back(inject_echo(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_word_cnt <= o_word_cnt + 1;
                if (expected_words.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected word %p", i_out_data);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.injected) o_echo_cnt <= o_echo_cnt + 1;
                    if (want.out_i !== i_out_data.out_i || want.out_q !== i_out_data.out_q
                            || want.injected !== i_out_data.injected
                            || want.out_last !== i_out_data.out_last) begin
                        if (o_fail_cnt < 10)
                            $display("mismatch: expected i=%0d q=%0d inj=%0b last=%0b, got i=%0d q=%0d inj=%0b last=%0b",
                                     want.out_i, want.out_q, want.injected, want.out_last,
                                     i_out_data.out_i, i_out_data.out_q,
                                     i_out_data.injected, i_out_data.out_last);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register settings and pulses of receive samples into the echo
// injector with random gaps and output stalls; the checker judges each word.
// ----------------------------------------------------------------------------
module testbench;
    import lcei_pkg::*;
    import lcei_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_cnt, pending, echo_cnt, word_cnt;
    int                    sent_cnt;
    int                    cycle_cnt;
    bit                    quiet_in, quiet_out;

    lcei_stream_if #(.T(t_sample_in))  in_ch ();
    lcei_stream_if #(.T(t_sample_out)) out_ch ();

    lfm_chirp_echo_injector_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    echo_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.data),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_echo_cnt  (echo_cnt),
        .o_word_cnt  (word_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output side: random stalls plus one long hold-off once 300 words have been sent
    initial begin
        int hold;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (sent_cnt < 300) begin
            out_ch.ready <= 1'b1;
            hold = quiet_out ? 0 : gap_len();
            @(posedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        forever begin
            out_ch.ready <= 1'b1;
            hold = quiet_out ? 0 : gap_len();
            @(posedge i_clk);
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until taken
    task automatic send_word(input logic [13:0] idx, input logic [15:0] si,
                             input logic [15:0] sq, input logic last);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data <= '{sample_index: idx, in_i: si, in_q: sq, in_last: last};
        do @(posedge i_clk); while (!in_ch.ready);
        sent_cnt++;
        gap = quiet_in ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // Drain the pipeline before touching the registers
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [31:0] amp, input logic [31:0] dly,
                           input logic [31:0] span, input logic [31:0] ns,
                           input logic [31:0] plen, input logic [31:0] rate,
                           input logic [31:0] car);
        wait_idle();
        write_reg(REG_AMPLITUDE, amp);
        write_reg(REG_DELAY, dly);
        write_reg(REG_SPAN, span);
        write_reg(REG_SAMPLES, ns);
        write_reg(REG_PULSE_LEN, plen);
        write_reg(REG_RATE, rate);
        write_reg(REG_CARRIER, car);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One pulse of consecutive indices, with stray words mixed in
    task automatic send_pulse(input int plen);
        for (int n = 0; n < plen; n++) begin
            if ($urandom_range(0, 19) == 0)
                send_word(14'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            send_word(14'(n), 16'($urandom), 16'($urandom), n == plen - 1);
        end
    endtask

    initial begin
        int plen, dly;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        sent_cnt = 0;
        cycle_cnt = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: amplitude zero, nothing injected
        send_word(14'd0, 16'h7fff, 16'h8000, 1'b0);
        send_word(14'h3fff, 16'h8000, 16'h7fff, 1'b1);

        // Full-scale echo from index zero, largest rate and carrier
        set_all(32'h7fff, 0, 32'h3fffff, 16384, 16384, 32'h7fffffff, 32'hffff);
        send_word(14'd0, 16'h7fff, 16'h7fff, 1'b0);
        send_word(14'd1, 16'h8000, 16'h8000, 1'b0);
        send_word(14'd2, 16'h0000, 16'hffff, 1'b0);
        send_word(14'h3fff, 16'h7fff, 16'h8000, 1'b1);

        // Zero pulse length disables injection
        set_all(32'h7fff, 0, 32'h3fffff, 100, 0, 32'h12345, 32'h4000);
        send_word(14'd0, 16'h0000, 16'h0000, 1'b0);
        send_word(14'd5, 16'h1234, 16'hfedc, 1'b1);

        // Pulse length beyond the limit, delay at its top, fraction of a sample
        set_all(32'hffffffff, 32'h3fffff, 32'h3fffff, 32'hffff, 32'h7fff,
                32'h80000000, 0);
        send_word(14'h3ffe, 16'h0100, 16'h0100, 1'b0);
        send_word(14'h3fff, 16'h8000, 16'h7fff, 1'b1);

        // Window edges with fractional delay and narrow span
        set_all(20000, 32'h00a80, 32'h500, 6, 40, 32'hfff00000, 32'h8000);
        for (int n = 8; n < 20; n++)
            send_word(14'(n), 16'($urandom), 16'($urandom), n == 19);

        // Random settings and well-formed pulses
        while (sent_cnt < 1050) begin
            plen = $urandom_range(16, 150);
            dly = $urandom_range(0, plen * 256);
            quiet_in = ($urandom_range(0, 4) == 0);
            quiet_out = ($urandom_range(0, 4) == 0);
            set_all(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32767),
                    ($urandom_range(0, 7) == 0) ? 32'($urandom) : dly,
                    $urandom_range(0, 60 * 256),
                    $urandom_range(0, 80),
                    ($urandom_range(0, 9) == 0) ? 32'($urandom) : plen,
                    $urandom, $urandom);
            send_pulse(plen);
            if ($urandom_range(0, 1) == 0) send_pulse(plen);
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("run: %0d sample words sent, %0d words checked, %0d carried an echo",
                 sent_cnt, word_cnt, echo_cnt);
        $display("run: register extremes, zero and oversized pulse length, saturation, stalls");
        if (fail_cnt == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lcei_pkg.sv
rtl/lcei_stream_if.sv
rtl/lcei_cordic_cell.sv
rtl/lcei_phase_front.sv
rtl/lfm_chirp_echo_injector_unit.sv
sim/lcei_tb_pkg.sv
sim/echo_checker.sv
sim/testbench.sv
